### rtl/core/cce_pkg.sv
// Shared types, codes and character tables for the control character escaper.
package cce_pkg;

  localparam int ByteW = 8;
  localparam int IdxW  = 3;

  localparam logic [1:0] K_PLAIN = 2'd0;  // byte passes through
  localparam logic [1:0] K_CESC  = 2'd1;  // backslash plus letter
  localparam logic [1:0] K_OCT   = 2'd2;  // backslash plus three octal digits
  localparam logic [1:0] K_XML   = 2'd3;  // XML entity

  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_AMP    = 8'h26;
  localparam logic [ByteW-1:0] CH_QUOT   = 8'h22;
  localparam logic [ByteW-1:0] CH_APOS   = 8'h27;
  localparam logic [ByteW-1:0] CH_LT     = 8'h3C;
  localparam logic [ByteW-1:0] CH_GT     = 8'h3E;
  localparam logic [ByteW-1:0] CTRL_MAX  = 8'd31;
  localparam logic [ByteW-1:0] CH_DEL    = 8'd127;

  // entity strings, first character in the top byte, zero padded
  localparam logic [47:0] XML_AMP  = {"&amp;", 8'h00};
  localparam logic [47:0] XML_QUOT = "&quot;";
  localparam logic [47:0] XML_APOS = "&apos;";
  localparam logic [47:0] XML_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] XML_GT   = {"&gt;", 16'h0000};

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [1:0]       kind;
    logic [IdxW-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic busy;   // in the middle of an expanded sequence
    logic pop;    // head entry fully emitted this cycle
  } back_stat_t;

  function automatic logic [ByteW-1:0] cesc_letter(logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    case (b)
      8'd7:    c = "a";
      8'd8:    c = "b";
      8'd9:    c = "t";
      8'd10:   c = "n";
      8'd11:   c = "v";
      8'd12:   c = "f";
      8'd13:   c = "r";
      default: c = CH_BSLASH;
    endcase
    return c;
  endfunction

  function automatic logic [ByteW-1:0] xml_char(logic [ByteW-1:0] b, logic [IdxW-1:0] idx);
    logic [47:0]     s;
    logic [IdxW-1:0] pos;
    case (b)
      CH_AMP:  s = XML_AMP;
      CH_QUOT: s = XML_QUOT;
      CH_APOS: s = XML_APOS;
      CH_LT:   s = XML_LT;
      default: s = XML_GT;
    endcase
    pos = IdxW'(5) - idx;
    return s[8*pos +: 8];
  endfunction

  function automatic logic [ByteW-1:0] seq_char(entry_t e, logic [IdxW-1:0] idx);
    logic [ByteW-1:0] c;
    case (e.kind)
      K_PLAIN: c = e.data;
      K_CESC:  c = (idx == '0) ? CH_BSLASH : cesc_letter(e.data);
      K_OCT: begin
        case (idx)
          3'd0:    c = CH_BSLASH;
          3'd1:    c = {6'b001100, e.data[7:6]};
          3'd2:    c = {5'b00110, e.data[5:3]};
          default: c = {5'b00110, e.data[2:0]};
        endcase
      end
      default: c = xml_char(e.data, idx);
    endcase
    return c;
  endfunction

endpackage

### rtl/core/cce_front.sv
// Front end: holds the XML mode register and classifies each accepted byte.
module cce_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              push,
  input  logic              q_full,
  input  logic [7:0]        in_byte,
  output logic              q_write,
  output cce_pkg::entry_t   q_entry
);
  import cce_pkg::*;

  logic escape_xml;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_xml <= 1'b0;
    end else if (cfg_write) begin
      escape_xml <= cfg_data;
    end
  end

  assign q_write = push && !q_full;

  always_comb begin
    q_entry.data = in_byte;
    if (in_byte inside {[8'd7:8'd13], CH_BSLASH}) begin
      q_entry.kind = K_CESC;
      q_entry.len  = IdxW'(2);
    end else if (escape_xml && in_byte == CH_AMP) begin
      q_entry.kind = K_XML;
      q_entry.len  = IdxW'(5);
    end else if (escape_xml && (in_byte inside {CH_QUOT, CH_APOS})) begin
      q_entry.kind = K_XML;
      q_entry.len  = IdxW'(6);
    end else if (escape_xml && (in_byte inside {CH_LT, CH_GT})) begin
      q_entry.kind = K_XML;
      q_entry.len  = IdxW'(4);
    end else if (in_byte <= CTRL_MAX || in_byte == CH_DEL) begin
      q_entry.kind = K_OCT;
      q_entry.len  = IdxW'(4);
    end else begin
      q_entry.kind = K_PLAIN;
      q_entry.len  = IdxW'(1);
    end
  end

endmodule

### rtl/core/cce_queue.sv
// Small register queue between the classifier and the expander.
module cce_queue #(
  parameter int Depth = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       write,
  input  cce_pkg::entry_t            wdata,
  input  logic                       read,
  output logic                       full,
  output logic                       valid,
  output cce_pkg::entry_t            rdata,
  output logic [$clog2(Depth+1)-1:0] count
);
  import cce_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth+1);

  entry_t            mem [Depth];
  logic [PtrW-1:0]   wptr;
  logic [PtrW-1:0]   rptr;
  logic [CntW-1:0]   count_next;
  logic              do_rd;

  assign full  = (count == CntW'(Depth));
  assign valid = (count != '0);
  assign rdata = mem[rptr];
  assign do_rd = read && valid;

  always_comb begin
    count_next = count;
    if (write && !do_rd) begin
      count_next = count + CntW'(1);
    end else if (do_rd && !write) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (write) begin
        wptr <= (wptr == PtrW'(Depth-1)) ? '0 : wptr + PtrW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PtrW'(Depth-1)) ? '0 : rptr + PtrW'(1);
      end
    end
  end

endmodule

### rtl/core/cce_back.sv
// Back end: walks the head entry a byte a cycle into the result register when free.
module cce_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  cce_pkg::entry_t     q_entry,
  input  logic                pop,
  output cce_pkg::back_stat_t stat,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import cce_pkg::*;

  logic [IdxW-1:0] idx;
  logic            ovalid;
  logic            load;
  logic            at_end;

  assign load   = !ovalid || pop;
  assign at_end = (idx == q_entry.len - IdxW'(1));

  assign stat.busy = (idx != '0);
  assign stat.pop  = load && q_valid && at_end;
  assign empty     = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      ovalid <= q_valid;
      if (q_valid) begin
        idx <= at_end ? '0 : idx + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_byte <= seq_char(q_entry, idx);
      out_last <= at_end;
    end
  end

endmodule

### rtl/core/control_char_escaper_core.sv
// Top level of the control character escaper: classifier, queue and expander.
// Takes one text byte per request and returns its escaped form one byte per
// result, out_last marking the final byte of each sequence. Plain bytes flow
// at one per cycle while results are popped, through a queue entry and then
// the result register; an expanded byte (C escape 2, octal escape 4, XML
// entity 4 to 6 bytes) holds the expander until its last byte is out, and
// the QUEUE_DEPTH entry queue absorbs input meanwhile before full rises.
// escape_xml is written through cfg_write/cfg_data and resets to 0.
module control_char_escaper_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import cce_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH+1);

  logic            q_write;
  entry_t          q_wentry;
  logic            q_valid;
  entry_t          q_head;
  logic [CntW-1:0] q_count;
  back_stat_t      back_stat;

  cce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .q_full    (full),
    .in_byte   (in_byte),
    .q_write   (q_write),
    .q_entry   (q_wentry)
  );

  cce_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .write (q_write),
    .wdata (q_wentry),
    .read  (back_stat.pop),
    .full  (full),
    .valid (q_valid),
    .rdata (q_head),
    .count (q_count)
  );

  cce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_head),
    .pop      (pop),
    .stat     (back_stat),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

`ifndef SYNTHESIS
  // mid-sequence the head entry must still be in the queue
  a_busy_has_head: assert property (@(posedge clk) disable iff (rst)
    back_stat.busy |-> q_valid)
    else $error("expander busy with empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CntW'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full && q_count == '0))
    else $error("not empty after reset");

  // request into empty queue, idle output: passes queue, then result register
  a_plain_latency: assert property (@(posedge clk) disable iff (rst)
    (q_write && q_count == '0 && empty) |=> ##1 !empty)
    else $error("result missing after request");
`endif

endmodule
